// ===== hdl/lshs_pkg.sv =====
// Shared types and codes for the limit switch homing sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lshs_pkg;

	// Register widths and configuration port layout.
	localparam int unsigned LIMIT_W   = 12;
	localparam int unsigned CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MOVE_OFF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH   = 2'd2;

	// Reset values of the limits.
	localparam logic [LIMIT_W-1:0] MOVE_OFF_RST = 12'd300;
	localparam logic [LIMIT_W-1:0] RELEASE_RST  = 12'd200;
	localparam logic [LIMIT_W-1:0] SEARCH_RST   = 12'd1000;

	// Motor drive codes.
	localparam logic [1:0] DRV_STOP = 2'd0;
	localparam logic [1:0] DRV_CW   = 2'd1;
	localparam logic [1:0] DRV_CCW  = 2'd2;

	// Switch codes.
	localparam logic [1:0] HIT_NONE = 2'd0;
	localparam logic [1:0] HIT_DOWN = 2'd1;
	localparam logic [1:0] HIT_UP   = 2'd2;

	// Status codes.
	localparam logic [2:0] ST_NEVER   = 3'd0;
	localparam logic [2:0] ST_RUNNING = 3'd1;
	localparam logic [2:0] ST_OK      = 3'd2;
	localparam logic [2:0] ST_STUCK   = 3'd3;
	localparam logic [2:0] ST_CW_TO   = 3'd4;
	localparam logic [2:0] ST_NO_REL  = 3'd5;
	localparam logic [2:0] ST_CCW_TO  = 3'd6;

	// Sequencer phases, one-hot.
	typedef enum logic [6:0] {
		PH_IDLE       = 7'b0000001,
		PH_OFF_CW     = 7'b0000010,
		PH_OFF_CCW    = 7'b0000100,
		PH_SEARCH_CW  = 7'b0001000,
		PH_REL_CCW    = 7'b0010000,
		PH_REL_CW     = 7'b0100000,
		PH_SEARCH_CCW = 7'b1000000
	} phase_t;

	// Current limit settings.
	typedef struct packed {
		logic [LIMIT_W-1:0] move_off_limit;
		logic [LIMIT_W-1:0] release_limit;
		logic [LIMIT_W-1:0] search_limit;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic [1:0] motor_drive;
		logic       busy_res;
		logic [2:0] status;
		logic [1:0] clockwise_hit;
		logic [1:0] counter_hit;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/limit_switch_homing_sequencer.sv =====
// Homing sequencer for a servo between two limit switches: top level.
// Depends on lshs_pkg, lshs_cfg and lshs_core.
//
// Every accepted item (a start command or a poll tick with both switch
// levels) yields exactly one result item. An item is registered on input,
// then applied to the sequencer state as it lands in the output register.
// A new item is taken every cycle unless the consumer stalls the output.
// The three tick limits must be written through the configuration port
// only while the block is idle; the block itself does not enforce it.
`default_nettype none

module limit_switch_homing_sequencer
	import lshs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 command,
	input  wire logic                 down_pressed,
	input  wire logic                 up_pressed,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                motor_drive,
	output logic                      busy_res,
	output logic [2:0]                status,
	output logic [1:0]                clockwise_hit,
	output logic [1:0]                counter_hit,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [LIMIT_W-1:0]   cfg_data
);

	cfg_t    cfg;
	result_t result;
	result_t out_q;
	logic    valid_s1, command_s1, down_s1, up_s1;
	logic    out_valid_q;
	logic    advance;

	lshs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The stage-one item moves on whenever the output register is free.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= command;
			down_s1    <= down_pressed;
			up_s1      <= up_pressed;
		end
	end

	lshs_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (valid_s1 && advance),
		.command      (command_s1),
		.down_pressed (down_s1),
		.up_pressed   (up_s1),
		.cfg          (cfg),
		.result       (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign motor_drive   = out_q.motor_drive;
	assign busy_res      = out_q.busy_res;
	assign status        = out_q.status;
	assign clockwise_hit = out_q.clockwise_hit;
	assign counter_hit   = out_q.counter_hit;

`ifndef ASSERT_OFF
	// A result is busy exactly when its status says running.
	a_busy_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (busy_res == (status == ST_RUNNING)))
		else $error("busy flag disagrees with status");

	// The motor turns exactly while the sequence runs.
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (busy_res == (motor_drive != DRV_STOP)))
		else $error("motor drive disagrees with busy flag");

	// With an empty output register the input side never stalls.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output register");

	// A held result does not change while the consumer stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(out_q))
		else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== hdl/lshs_cfg.sv =====
// Configuration registers of the homing sequencer: three tick limits.
// Depends on lshs_pkg.
`default_nettype none

module lshs_cfg
	import lshs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [LIMIT_W-1:0]   cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	// Write the addressed limit; an index past the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move_off_limit <= MOVE_OFF_RST;
			cfg_q.release_limit  <= RELEASE_RST;
			cfg_q.search_limit   <= SEARCH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MOVE_OFF: cfg_q.move_off_limit <= cfg_data;
				CFG_RELEASE:  cfg_q.release_limit  <= cfg_data;
				CFG_SEARCH:   cfg_q.search_limit   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/lshs_core.sv =====
// Sequencer state and next-state logic: applies one item per step.
// Depends on lshs_pkg.
`default_nettype none

module lshs_core
	import lshs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire logic command,
	input  wire logic down_pressed,
	input  wire logic up_pressed,
	input  wire cfg_t cfg,
	output result_t   result
);

	phase_t             phase_q, phase_d;
	logic [LIMIT_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [1:0]         first_hit_q, first_hit_d;
	logic [1:0]         second_hit_q, second_hit_d;
	logic [2:0]         result_q, result_d;
	logic               any_pressed, still_pressed;
	logic [1:0]         hit_now;
	logic               over_move, over_release, over_search;

	// Switch decode and limit compares against the incremented count.
	always_comb begin
		any_pressed   = down_pressed | up_pressed;
		still_pressed = (first_hit_q == HIT_DOWN) ? down_pressed : up_pressed;
		hit_now       = up_pressed ? HIT_UP : (down_pressed ? HIT_DOWN : HIT_NONE);
		elapsed_inc   = elapsed_q + 1'b1;
		over_move     = elapsed_inc >= cfg.move_off_limit;
		over_release  = elapsed_inc >= cfg.release_limit;
		over_search   = elapsed_inc >= cfg.search_limit;
	end

	// Next state for the item at hand.
	always_comb begin
		phase_d      = phase_q;
		elapsed_d    = elapsed_q;
		first_hit_d  = first_hit_q;
		second_hit_d = second_hit_q;
		result_d     = result_q;
		if (command && phase_q == PH_IDLE) begin
			result_d     = ST_RUNNING;
			second_hit_d = HIT_NONE;
			elapsed_d    = '0;
			phase_d      = any_pressed ? PH_OFF_CW : PH_SEARCH_CW;
		end else begin
			case (phase_q)
				PH_OFF_CW: begin
					if (!any_pressed) begin
						phase_d   = PH_SEARCH_CW;
						elapsed_d = '0;
					end else if (over_move) begin
						phase_d   = PH_OFF_CCW;
						elapsed_d = '0;
					end else begin
						elapsed_d = elapsed_inc;
					end
				end
				PH_OFF_CCW: begin
					if (!any_pressed) begin
						phase_d   = PH_SEARCH_CW;
						elapsed_d = '0;
					end else if (over_move) begin
						phase_d   = PH_IDLE;
						elapsed_d = '0;
						result_d  = ST_STUCK;
					end else begin
						elapsed_d = elapsed_inc;
					end
				end
				PH_SEARCH_CW: begin
					if (any_pressed) begin
						first_hit_d = hit_now;
						phase_d     = PH_REL_CCW;
						elapsed_d   = '0;
					end else if (over_search) begin
						phase_d   = PH_IDLE;
						elapsed_d = '0;
						result_d  = ST_CW_TO;
					end else begin
						elapsed_d = elapsed_inc;
					end
				end
				PH_REL_CCW: begin
					if (!still_pressed) begin
						phase_d   = PH_SEARCH_CCW;
						elapsed_d = '0;
					end else if (over_release) begin
						phase_d   = PH_REL_CW;
						elapsed_d = '0;
					end else begin
						elapsed_d = elapsed_inc;
					end
				end
				PH_REL_CW: begin
					if (!still_pressed) begin
						phase_d   = PH_SEARCH_CCW;
						elapsed_d = '0;
					end else if (over_release) begin
						phase_d   = PH_IDLE;
						elapsed_d = '0;
						result_d  = ST_NO_REL;
					end else begin
						elapsed_d = elapsed_inc;
					end
				end
				PH_SEARCH_CCW: begin
					if (any_pressed) begin
						second_hit_d = hit_now;
						phase_d      = PH_IDLE;
						elapsed_d    = '0;
						result_d     = ST_OK;
					end else if (over_search) begin
						phase_d   = PH_IDLE;
						elapsed_d = '0;
						result_d  = ST_CCW_TO;
					end else begin
						elapsed_d = elapsed_inc;
					end
				end
				default: begin
					phase_d   = PH_IDLE;
					elapsed_d = '0;
				end
			endcase
		end
	end

	// State registers advance once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			elapsed_q    <= '0;
			first_hit_q  <= HIT_NONE;
			second_hit_q <= HIT_NONE;
			result_q     <= ST_NEVER;
		end else if (step) begin
			phase_q      <= phase_d;
			elapsed_q    <= elapsed_d;
			first_hit_q  <= first_hit_d;
			second_hit_q <= second_hit_d;
			result_q     <= result_d;
		end
	end

	// The result shows the state after the item is applied.
	always_comb begin
		case (phase_d)
			PH_OFF_CW, PH_SEARCH_CW, PH_REL_CW:      result.motor_drive = DRV_CW;
			PH_OFF_CCW, PH_REL_CCW, PH_SEARCH_CCW:   result.motor_drive = DRV_CCW;
			default:                                 result.motor_drive = DRV_STOP;
		endcase
		result.busy_res      = (phase_d != PH_IDLE);
		result.status        = result_d;
		result.clockwise_hit = first_hit_d;
		result.counter_hit   = second_hit_d;
	end

endmodule

`default_nettype wire
